FILE: hw/rtl/fmrc_pkg.sv
`timescale 1ns / 1ps

package fmrc_pkg;

  localparam int unsigned ADDR_W         = 64;
  localparam int unsigned PAGES_W        = 52;
  localparam int unsigned TYPE_W         = 4;
  localparam int unsigned APB_ADDR_W     = 4;
  localparam int unsigned APB_DATA_W     = 64;
  // Descriptor lengths are always counted in 4 KiB pages.
  localparam int unsigned DESC_PAGE_SHIFT = 12;

  localparam logic [ADDR_W-1:0] BASE_RESET  = 64'hE000_0000_0000_0000;
  localparam logic [ADDR_W-1:0] LIMIT_RESET = 64'h0000_0000_4000_0000;

  // Usable descriptor types.
  localparam logic [TYPE_W-1:0] MT_LOADER_CODE  = 4'd1;
  localparam logic [TYPE_W-1:0] MT_LOADER_DATA  = 4'd2;
  localparam logic [TYPE_W-1:0] MT_BOOT_CODE    = 4'd3;
  localparam logic [TYPE_W-1:0] MT_BOOT_DATA    = 4'd4;
  localparam logic [TYPE_W-1:0] MT_CONVENTIONAL = 4'd7;

  // Register select, taken from paddr bit 3 (registers sit at 8-byte strides).
  typedef enum logic [0:0] {
    REG_VIRTUAL_BASE  = 1'b0,
    REG_ADDRESS_LIMIT = 1'b1
  } fmrc_reg_e;

  typedef struct packed {
    logic                flush;
    logic [TYPE_W-1:0]   mem_type;
    logic [ADDR_W-1:0]   desc_addr;
    logic [PAGES_W-1:0]  page_cnt;
  } fmrc_in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
  } fmrc_out_t;

  // Registered descriptor word handed to the merge stage.
  typedef struct packed {
    logic              flush;
    logic              usable;
    logic [ADDR_W-1:0] cur_start;
    logic [ADDR_W-1:0] cur_len;
  } fmrc_desc_t;

  // Handshake between descriptor stage and merge stage.
  typedef struct packed {
    logic       valid;
    fmrc_desc_t desc;
  } fmrc_stage_t;

endpackage

FILE: hw/rtl/fmrc_cfg_regs.sv
`timescale 1ns / 1ps

module fmrc_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fmrc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fmrc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fmrc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output logic [fmrc_pkg::ADDR_W-1:0]       virtual_base_o,
  output logic [fmrc_pkg::ADDR_W-1:0]       address_limit_o
);
  import fmrc_pkg::*;

  logic [ADDR_W-1:0] base_q, base_d;
  logic [ADDR_W-1:0] limit_q, limit_d;
  logic              wr_en;
  fmrc_reg_e         sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = fmrc_reg_e'(paddr[3]);

  always_comb begin
    base_d  = base_q;
    limit_d = limit_q;
    if (wr_en) begin
      case (sel)
        REG_VIRTUAL_BASE:  base_d  = pwdata;
        REG_ADDRESS_LIMIT: limit_d = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_VIRTUAL_BASE:  prdata = base_q;
      REG_ADDRESS_LIMIT: prdata = limit_q;
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BASE_RESET;
      limit_q <= LIMIT_RESET;
    end else begin
      base_q  <= base_d;
      limit_q <= limit_d;
    end
  end

  assign virtual_base_o  = base_q;
  assign address_limit_o = limit_q;

endmodule

FILE: hw/rtl/fmrc_desc_stage.sv
`timescale 1ns / 1ps

module fmrc_desc_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fmrc_pkg::fmrc_in_t            in_word_i,
  input  logic [fmrc_pkg::ADDR_W-1:0]   virtual_base_i,
  input  logic [fmrc_pkg::ADDR_W-1:0]   address_limit_i,
  input  logic                          advance_i,
  output fmrc_pkg::fmrc_stage_t         stage_o
);
  import fmrc_pkg::*;

  logic       valid_q, valid_d;
  fmrc_desc_t desc_q, desc_d;
  logic       accept;
  logic       type_ok;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    type_ok = in_word_i.mem_type inside {MT_LOADER_CODE, MT_LOADER_DATA, MT_BOOT_CODE,
                                         MT_BOOT_DATA, MT_CONVENTIONAL};
    desc_d.flush     = in_word_i.flush;
    desc_d.usable    = type_ok && (in_word_i.desc_addr <= address_limit_i);
    desc_d.cur_start = virtual_base_i + in_word_i.desc_addr;
    desc_d.cur_len   = {in_word_i.page_cnt, {DESC_PAGE_SHIFT{1'b0}}};
  end

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_q <= desc_d;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.desc  = desc_q;

endmodule

FILE: hw/rtl/fmrc_merge_stage.sv
`timescale 1ns / 1ps

module fmrc_merge_stage #(
  parameter int unsigned PAGE_SHIFT = 14
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fmrc_pkg::fmrc_stage_t  stage_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output fmrc_pkg::fmrc_out_t    out_word_o
);
  import fmrc_pkg::*;

  localparam logic [ADDR_W-1:0] PAGE_LOW   = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);
  localparam logic [ADDR_W-1:0] GRAIN_MASK = ~PAGE_LOW;

  logic              held_valid_q, held_valid_d;
  logic [ADDR_W-1:0] held_start_q, held_start_d;
  logic [ADDR_W-1:0] held_end_q, held_end_d;
  logic              out_valid_q, out_valid_d;
  fmrc_out_t         out_q, out_d;

  logic              out_free;
  logic              step;
  logic              emit;
  logic [ADDR_W-1:0] cur_end;
  logic [ADDR_W-1:0] rnd_start, rnd_end;
  logic              nonempty;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign advance_o = out_free;
  assign step      = stage_i.valid && out_free;

  assign cur_end   = stage_i.desc.cur_start + stage_i.desc.cur_len;
  assign rnd_start = (held_start_q + PAGE_LOW) & GRAIN_MASK;
  assign rnd_end   = held_end_q & GRAIN_MASK;
  assign nonempty  = held_valid_q && (rnd_end > rnd_start);

  always_comb begin
    held_valid_d = held_valid_q;
    held_start_d = held_start_q;
    held_end_d   = held_end_q;
    emit         = 1'b0;
    if (step) begin
      if (stage_i.desc.flush) begin
        emit         = nonempty;
        held_valid_d = 1'b0;
        held_start_d = '0;
        held_end_d   = '0;
      end else if (stage_i.desc.usable) begin
        if (held_valid_q && (held_end_q == stage_i.desc.cur_start)) begin
          held_end_d = cur_end;
        end else begin
          // breaks contiguity: flush out the old range, start a new one
          emit         = nonempty;
          held_valid_d = 1'b1;
          held_start_d = stage_i.desc.cur_start;
          held_end_d   = cur_end;
        end
      end
    end
  end

  always_comb begin
    out_valid_d       = out_free ? emit : out_valid_q;
    out_d.range_start = rnd_start;
    out_d.range_end   = rnd_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
      held_start_q <= '0;
      held_end_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
      held_start_q <= held_start_d;
      held_end_q   <= held_end_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: hw/rtl/free_memory_range_coalescer_unit.sv
`timescale 1ns / 1ps
// A descriptor word that closes a range puts its result on the output after it passes
//   the input register, then the result register.
// Throughput: one descriptor word per cycle; the input stalls only while a result
//   waits in the output register and the consumer stalls it.
// Reset (rst_ni, async, active low): held range cleared, pipeline empty,
//   virtual_base = 0xE000000000000000, address_limit = 0x40000000.

module free_memory_range_coalescer_unit #(
  parameter int unsigned PAGE_SHIFT = 14  // rounding granule of emitted ranges, 12..16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // descriptor input
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fmrc_pkg::fmrc_in_t                in_word_i,
  // range output
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fmrc_pkg::fmrc_out_t               out_word_o,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [fmrc_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fmrc_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fmrc_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import fmrc_pkg::*;

  logic [ADDR_W-1:0] virtual_base;
  logic [ADDR_W-1:0] address_limit;
  fmrc_stage_t       stage;
  logic              advance;

  // Two 64-bit registers at byte offsets 0x0 and 0x8.
  fmrc_cfg_regs u_cfg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .virtual_base_o  (virtual_base),
    .address_limit_o (address_limit)
  );

  // Stage 1: type/limit check and base offset add, registered.
  fmrc_desc_stage u_desc (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_word_i       (in_word_i),
    .virtual_base_i  (virtual_base),
    .address_limit_i (address_limit),
    .advance_i       (advance),
    .stage_o         (stage)
  );

  // Stage 2: end add, contiguity compare, page rounding of the held range,
  // result register. The held range updates only when the output can take a word.
  fmrc_merge_stage #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

FILE: hw/rtl/fmrc_checker.sv
`timescale 1ns / 1ps

module fmrc_checker #(
  parameter int unsigned PAGE_SHIFT = 14
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fmrc_pkg::fmrc_out_t out_word_o
);
  import fmrc_pkg::*;

  localparam logic [ADDR_W-1:0] PAGE_LOW = (ADDR_W'(1) << PAGE_SHIFT) - ADDR_W'(1);

  // A stalled result word stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // Only non-empty ranges leave the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_word_o.range_end > out_word_o.range_start)
    else $error("empty range emitted");

  // Emitted ranges are page aligned on both ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_word_o.range_start & PAGE_LOW) == '0) &&
                    ((out_word_o.range_end & PAGE_LOW) == '0))
    else $error("unaligned range emitted");

  // Input back-pressure only arises from a blocked output word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

endmodule

bind free_memory_range_coalescer_unit fmrc_checker #(
  .PAGE_SHIFT (PAGE_SHIFT)
) u_fmrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

FILE: test/fmrc_range_checker.sv
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts the emitted ranges
// and compares them in order against what the block delivers.
module fmrc_range_checker #(
  parameter int unsigned PAGE_SHIFT = 14
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  fmrc_pkg::fmrc_in_t                in_word_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  fmrc_pkg::fmrc_out_t               out_word_i,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic                              pready_i,
  input  logic [fmrc_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [fmrc_pkg::APB_DATA_W-1:0]   pwdata_i,
  output int unsigned                       fail_count_o,
  output int unsigned                       pending_o
);
  import fmrc_pkg::*;

  localparam logic [ADDR_W-1:0] GRAIN_MASK = ~((64'd1 << PAGE_SHIFT) - 64'd1);

  logic [ADDR_W-1:0] virt_base;
  logic [ADDR_W-1:0] addr_limit;
  logic              held_valid;
  logic [ADDR_W-1:0] held_start;
  logic [ADDR_W-1:0] held_end;
  fmrc_out_t         range_q[$];
  int unsigned       fails;

  function automatic bit usable_type(input logic [TYPE_W-1:0] t);
    return t == MT_LOADER_CODE || t == MT_LOADER_DATA || t == MT_BOOT_CODE ||
           t == MT_BOOT_DATA || t == MT_CONVENTIONAL;
  endfunction

  // Round the held range inward to whole granules; queue it if anything is left.
  task automatic close_held();
    fmrc_out_t r;
    r.range_start = (held_start + ~GRAIN_MASK) & GRAIN_MASK;
    r.range_end   = held_end & GRAIN_MASK;
    if (r.range_end > r.range_start) range_q.push_back(r);
  endtask

  task automatic coalesce_word(input fmrc_in_t w);
    logic [ADDR_W-1:0] cs;
    logic [ADDR_W-1:0] ce;
    if (w.flush) begin
      if (held_valid) close_held();
      held_valid = 1'b0;
      held_start = '0;
      held_end   = '0;
    end else if (usable_type(w.mem_type) && w.desc_addr <= addr_limit) begin
      cs = virt_base + w.desc_addr;
      ce = cs + (64'(w.page_cnt) << DESC_PAGE_SHIFT);
      if (!held_valid) begin
        held_valid = 1'b1;
        held_start = cs;
      end else if (held_end != cs) begin
        close_held();
        held_start = cs;
      end
      held_end = ce;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    fmrc_out_t want;
    if (!rst_ni) begin
      virt_base  = BASE_RESET;
      addr_limit = LIMIT_RESET;
      held_valid = 1'b0;
      held_start = '0;
      held_end   = '0;
      range_q.delete();
      fails      = 0;
    end else begin
      // results first: nothing accepted at this edge can leave at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (range_q.size() == 0) begin
          $error("range_start: expected none, got %h", out_word_i.range_start);
          fails++;
        end else begin
          want = range_q.pop_front();
          if (out_word_i.range_start !== want.range_start) begin
            $error("range_start: expected %h, got %h", want.range_start,
                   out_word_i.range_start);
            fails++;
          end
          if (out_word_i.range_end !== want.range_end) begin
            $error("range_end: expected %h, got %h", want.range_end, out_word_i.range_end);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) coalesce_word(in_word_i);
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2:0] == 3'b000) begin
        case (fmrc_reg_e'(paddr_i[3]))
          REG_VIRTUAL_BASE:  virt_base  = pwdata_i;
          REG_ADDRESS_LIMIT: addr_limit = pwdata_i;
          default: ;
        endcase
      end
    end
    fail_count_o <= fails;
    pending_o    <= range_q.size();
  end

endmodule

FILE: test/free_memory_range_coalescer_unit_tb.sv
`timescale 1ns / 1ps

module free_memory_range_coalescer_unit_tb;
  import fmrc_pkg::*;

  localparam int unsigned PAGE_SHIFT  = 14;
  localparam int unsigned SETTLE      = 8;       // > pipeline depth of the block
  localparam int unsigned HOLD_LEN    = 200;     // long consumer hold-off, in cycles
  localparam int unsigned CYCLE_LIMIT = 400000;

  // Flow-control profiles for the two channels.
  typedef enum logic [1:0] {
    FLOW_FREE,
    FLOW_SEND_GAPS,
    FLOW_RECV_STALLS,
    FLOW_BOTH
  } flow_e;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  fmrc_in_t              in_word_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  fmrc_out_t             out_word_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  int unsigned fail_count;
  int unsigned pending;

  // Stimulus-side mirror of the limit register, used only to aim addresses below it.
  logic [ADDR_W-1:0] cur_limit = LIMIT_RESET;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_armed     = 1'b0;
  int unsigned hold_cycles    = 0;
  int unsigned words_sent     = 0;
  int unsigned cycle_count    = 0;

  logic [TYPE_W-1:0] usable_types [5] = '{MT_LOADER_CODE, MT_LOADER_DATA, MT_BOOT_CODE,
                                          MT_BOOT_DATA, MT_CONVENTIONAL};

  free_memory_range_coalescer_unit #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  fmrc_range_checker #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_range_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_i   (out_word_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a range that never shows up ends here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Consumer side. The one-time hold-off keeps stall high until hold_cycles reaches
  // HOLD_LEN, so the output register fills and the block must push back on its input.
  always @(posedge clk_i) begin
    if (hold_armed && hold_cycles < HOLD_LEN) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [PAGES_W-1:0] rand_pages();
    return PAGES_W'(rand64());
  endfunction

  function automatic fmrc_in_t mk_word(input logic f, input logic [TYPE_W-1:0] t,
                                       input logic [ADDR_W-1:0] a,
                                       input logic [PAGES_W-1:0] p);
    fmrc_in_t w;
    w.flush     = f;
    w.mem_type  = t;
    w.desc_addr = a;
    w.page_cnt  = p;
    return w;
  endfunction

  // Start address of a run: at or below the current limit, mostly 4 KiB aligned.
  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] a;
    a = rand64();
    if (cur_limit != '1) a = a % (cur_limit + 64'd1);
    if ($urandom_range(3) != 0) a[11:0] = '0;
    return a;
  endfunction

  // Anything goes: random type, full-width address and length, occasional flush.
  function automatic fmrc_in_t rand_word();
    fmrc_in_t w;
    w.flush     = ($urandom_range(7) == 0);
    w.mem_type  = TYPE_W'($urandom);
    w.desc_addr = ($urandom_range(1) == 0) ? rand64() : pick_addr();
    w.page_cnt  = ($urandom_range(1) == 0) ? rand_pages() : PAGES_W'($urandom_range(40));
    return w;
  endfunction

  // Offer one word, with optional idle cycles in front. Stall is sampled at the
  // falling edge; it only moves at rising edges, so the sample holds for the
  // edge that follows.
  task automatic send_word(input fmrc_in_t w);
    logic taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    words_sent++;
  endtask

  // Stop offering, wait until every predicted range has come out, then let the
  // pipeline run dry (words that close nothing may still be in flight).
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One APB write: setup cycle, then access until pready. Leaves psel high so
  // a second write can follow with its setup cycle right away.
  task automatic write_reg(input fmrc_reg_e sel, input logic [63:0] value);
    logic done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
  endtask

  // Only called with the block idle.
  task automatic configure(input logic [63:0] base, input logic [63:0] limit);
    write_reg(REG_VIRTUAL_BASE, base);
    write_reg(REG_ADDRESS_LIMIT, limit);
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    cur_limit = limit;
    @(posedge clk_i);
  endtask

  task automatic set_flow(input flow_e mode);
    case (mode)
      FLOW_FREE:        begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      FLOW_SEND_GAPS:   begin send_idle_pct = 65; recv_stall_pct <= 0;  end
      FLOW_RECV_STALLS: begin send_idle_pct = 0;  recv_stall_pct <= 65; end
      default:          begin send_idle_pct = 14; recv_stall_pct <= 14; end
    endcase
  endtask

  // A memory map fragment: mostly back-to-back descriptors that should merge,
  // with gaps here and there, usually closed by a flush. In squeeze mode every
  // descriptor is usable, long enough to survive rounding, and followed by a
  // gap, so nearly every word closes a range.
  task automatic send_run(input bit squeeze);
    fmrc_in_t          w;
    logic [ADDR_W-1:0] addr;
    int unsigned       len;
    len  = $urandom_range(1, 12);
    addr = pick_addr();
    repeat (len) begin
      w.flush     = 1'b0;
      w.mem_type  = (!squeeze && $urandom_range(9) == 0) ? TYPE_W'($urandom)
                                                         : usable_types[$urandom_range(4)];
      w.desc_addr = addr;
      if (squeeze)
        w.page_cnt = PAGES_W'($urandom_range(8, 24));
      else if ($urandom_range(19) == 0)
        w.page_cnt = rand_pages();
      else
        w.page_cnt = PAGES_W'($urandom_range(24));
      send_word(w);
      addr = addr + (64'(w.page_cnt) << DESC_PAGE_SHIFT);
      if (squeeze || $urandom_range(3) == 0)
        addr = addr + (64'($urandom_range(1, 64)) << DESC_PAGE_SHIFT);
      else if ($urandom_range(15) == 0)
        addr = addr + 64'($urandom_range(1, 4095));  // misaligned jump
    end
    if (squeeze || $urandom_range(4) != 0) begin
      w = rand_word();
      w.flush = 1'b1;
      send_word(w);
    end
  endtask

  task automatic run_phase(input logic [63:0] base, input logic [63:0] limit,
                           input flow_e mode, input int unsigned count, input bit squeeze);
    int unsigned goal;
    configure(base, limit);
    set_flow(mode);
    hold_armed <= squeeze;
    goal = words_sent + count;
    while (words_sent < goal) begin
      if (!squeeze && $urandom_range(6) == 0)
        send_word(rand_word());
      else
        send_run(squeeze);
    end
    hold_armed <= 1'b0;
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed: reset values of the registers ----
    send_word(mk_word(1'b1, 4'd0, 64'h0, 52'h0));                 // flush, nothing held
    send_word(mk_word(1'b0, 4'd0, 64'h1000, 52'h4));              // reserved types dropped
    send_word(mk_word(1'b0, 4'd6, 64'h1000, 52'h4));
    send_word(mk_word(1'b0, 4'd15, 64'h1000, 52'h4));
    send_word(mk_word(1'b0, MT_CONVENTIONAL, LIMIT_RESET + 64'h1000, 52'h4)); // above limit
    send_word(mk_word(1'b0, MT_LOADER_CODE, 64'h0010_0000, 52'h4));  // first usable: held
    send_word(mk_word(1'b0, MT_LOADER_DATA, 64'h0010_4000, 52'h4));  // abuts: merged
    send_word(mk_word(1'b0, MT_BOOT_CODE, 64'h0020_0000, 52'h1));    // gap: emits the merge
    send_word(mk_word(1'b0, MT_BOOT_DATA, 64'h0030_0000, 52'h1));    // 4 KiB, extended by the next
    send_word(mk_word(1'b0, MT_CONVENTIONAL, 64'h0030_1000, 52'h3));
    send_word(mk_word(1'b0, MT_CONVENTIONAL, LIMIT_RESET, '1));     // at the limit, max length
    send_word(mk_word(1'b1, 4'd0, 64'h0, 52'h0));                   // wrapped range is empty
    send_word(mk_word(1'b1, 4'd0, 64'h0, 52'h0));                   // and again with nothing
    send_word(mk_word(1'b0, MT_LOADER_CODE, 64'h0, 52'h0));         // zero length held
    send_word(mk_word(1'b1, 4'd0, 64'h0, 52'h0));                   // empty: no result
    drain();

    // ---- directed: wrap-around at the top of the address space ----
    configure(64'hFFFF_FFFF_FFFF_F000, '1);
    send_word(mk_word(1'b0, MT_CONVENTIONAL, 64'h0, 52'd17));      // end wraps past 2^64
    send_word(mk_word(1'b1, 4'd0, 64'h0, 52'h0));                  // start rounds up to 0
    send_word(mk_word(1'b0, MT_LOADER_DATA, '1, 52'h1));           // max address accepted
    send_word(mk_word(1'b1, '1, '1, '1));                          // flush, other fields set
    drain();

    // ---- directed: zero base, zero limit ----
    configure(64'h0, 64'h0);
    send_word(mk_word(1'b0, MT_CONVENTIONAL, 64'h0, 52'h5));
    send_word(mk_word(1'b0, MT_CONVENTIONAL, 64'h5000, 52'h5));     // above the limit
    send_word(mk_word(1'b0, MT_CONVENTIONAL, 64'h0, 52'h3));        // out of order: emits
    send_word(mk_word(1'b1, 4'd0, 64'h0, 52'h0));
    drain();

    // ---- random phases over several register settings and flow profiles ----
    run_phase(BASE_RESET, LIMIT_RESET, FLOW_FREE, 250, 1'b0);
    run_phase(rand64(), rand64() >> $urandom_range(0, 40), FLOW_SEND_GAPS, 250, 1'b0);
    run_phase(64'h0, '1, FLOW_RECV_STALLS, 250, 1'b0);
    run_phase('1, LIMIT_RESET, FLOW_BOTH, 250, 1'b0);
    // consumer holds off while the producer keeps pushing: input must stall
    run_phase(BASE_RESET, LIMIT_RESET, FLOW_FREE, 200, 1'b1);
    run_phase(rand64(), '1, FLOW_BOTH, 200, 1'b0);
    run_phase(rand64(), 64'($urandom), FLOW_SEND_GAPS, 200, 1'b0);

    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
